FILE: rtl/core/note_queue_wavetable_synth_top_assert.svh
// Assertion macros for the note queue wavetable synth.
// Used by note_queue_wavetable_synth_top; expects clk_i and rst_ni in scope.
`ifndef NOTE_QUEUE_WAVETABLE_SYNTH_TOP_ASSERT_SVH
`define NOTE_QUEUE_WAVETABLE_SYNTH_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NQWS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NQWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/nqws_pkg.sv
// Shared types, constants and tables for the note queue wavetable synth.
// No dependencies.
package nqws_pkg;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned TABLE_LENGTH = 32;
  localparam int unsigned NOTE_COUNT   = 60;
  localparam int unsigned DVD_W        = 23;
  localparam int unsigned DSR_W        = 12;

  localparam logic [27:0] CLOCK_RESET  = 28'd48000000;
  localparam logic [2:0]  VOLUME_RESET = 3'd7;
  localparam logic [23:0] RELOAD_RESET = 24'(48000000 / 14080 - 1);
  localparam logic [5:0]  NOTE_MAX     = 6'(NOTE_COUNT - 1);
  localparam logic [7:0]  DIV_SILENT   = 8'd255;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_NOTE    = 2'd1,
    ACT_CLOCK   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_CLOCK  = 2'd0,
    CFG_VOLUME = 2'd1
  } cfg_index_e;

  typedef enum logic [2:0] {
    WAVE_SILENT = 3'd0,
    WAVE_SINE   = 3'd1,
    WAVE_SQUARE = 3'd2,
    WAVE_RAMP   = 3'd3,
    WAVE_TRI    = 3'd4
  } wave_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_POP,
    ST_FDIV,
    ST_SAMP,
    ST_SDIV,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [11:0] freq;
    logic [2:0]  wave;
    logic [15:0] len;
  } note_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  localparam logic [11:0] NOTE_HZ [NOTE_COUNT] = '{
    12'd131, 12'd139, 12'd148, 12'd156, 12'd165, 12'd175, 12'd185, 12'd196,
    12'd207, 12'd220, 12'd233, 12'd247, 12'd262, 12'd277, 12'd294, 12'd311,
    12'd330, 12'd349, 12'd370, 12'd392, 12'd415, 12'd440, 12'd466, 12'd494,
    12'd523, 12'd554, 12'd587, 12'd622, 12'd659, 12'd698, 12'd740, 12'd784,
    12'd830, 12'd880, 12'd932, 12'd988, 12'd1046, 12'd1109, 12'd1174, 12'd1244,
    12'd1318, 12'd1397, 12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865,
    12'd1975, 12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
    12'd2960, 12'd3136, 12'd3322, 12'd3440, 12'd3729, 12'd3951
  };

  localparam logic [11:0] SINE_TBL [TABLE_LENGTH] = '{
    12'd2047, 12'd2447, 12'd2831, 12'd3185, 12'd3498, 12'd3750, 12'd3939, 12'd4056,
    12'd4095, 12'd4056, 12'd3939, 12'd3750, 12'd3495, 12'd3185, 12'd2831, 12'd2447,
    12'd2047, 12'd1647, 12'd1263, 12'd909, 12'd599, 12'd344, 12'd155, 12'd38,
    12'd0, 12'd38, 12'd155, 12'd344, 12'd599, 12'd909, 12'd1263, 12'd1647
  };

  localparam logic [11:0] SAW_TBL [TABLE_LENGTH] = '{
    12'd0, 12'd132, 12'd264, 12'd396, 12'd528, 12'd660, 12'd792, 12'd924,
    12'd1056, 12'd1188, 12'd1320, 12'd1452, 12'd1584, 12'd1716, 12'd1848, 12'd1980,
    12'd2112, 12'd2245, 12'd2377, 12'd2509, 12'd2641, 12'd2773, 12'd2905, 12'd3037,
    12'd3169, 12'd3301, 12'd3433, 12'd3565, 12'd3697, 12'd3829, 12'd3961, 12'd4095
  };

  localparam logic [11:0] TRI_TBL [TABLE_LENGTH] = '{
    12'd0, 12'd264, 12'd528, 12'd792, 12'd1056, 12'd1320, 12'd1584, 12'd1848,
    12'd2112, 12'd2377, 12'd2641, 12'd2905, 12'd3169, 12'd3433, 12'd3697, 12'd3961,
    12'd3965, 12'd3701, 12'd3437, 12'd3173, 12'd2909, 12'd2645, 12'd2381, 12'd2117,
    12'd1853, 12'd1589, 12'd1324, 12'd1060, 12'd796, 12'd532, 12'd268, 12'd4
  };

  function automatic logic [11:0] wave_value(input logic [2:0] kind, input logic [4:0] idx);
    logic [11:0] v;
    case (kind)
      WAVE_SINE:   v = SINE_TBL[idx];
      WAVE_SQUARE: v = idx[4] ? 12'd0 : 12'd4095;
      WAVE_RAMP:   v = SAW_TBL[idx];
      WAVE_TRI:    v = TRI_TBL[idx];
      default:     v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/nqws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nqws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/nqws_div.sv
// Restoring divider, one quotient bit per cycle, shared by period and sample math.
// Depends on nqws_pkg.
module nqws_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nqws_pkg::div_req_t           req_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [nqws_pkg::DVD_W-1:0]   quotient_o
);

  localparam int unsigned CNT_W = $clog2(nqws_pkg::DVD_W + 1);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [nqws_pkg::DVD_W-1:0]   quo_q, quo_d;
  logic [nqws_pkg::DSR_W-1:0]   rem_q, rem_d;
  logic [nqws_pkg::DSR_W-1:0]   dsr_q, dsr_d;
  logic [nqws_pkg::DSR_W:0]     trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, quo_q[nqws_pkg::DVD_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(nqws_pkg::DVD_W);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = nqws_pkg::DSR_W'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[nqws_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[nqws_pkg::DSR_W-1:0];
        quo_d = {quo_q[nqws_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/core/note_queue_wavetable_synth_top.sv
// Top level of the note queue wavetable synth: sequencer, queue, state, outputs.
// Depends on nqws_pkg, nqws_ram, nqws_div and note_queue_wavetable_synth_top_assert.svh.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one beat per action: enqueue a
//   note, note-timer tick (may dispatch the next queued note), clock tick, or none.
//   Every accepted beat yields exactly one result beat on out_valid_o/out_ready_i
//   with the current DAC sample, play flag, queue fill and drop flag.
//   The config channel (cfg_valid_i/cfg_ready_o) is always ready; index 0 sets
//   the core clock in Hz, index 1 the volume. Write it only while idle.
//   Datapath: the sample is divided by the volume divisor in the shared
//   one-bit-per-cycle divider (23 steps); a dispatch that changes frequency
//   runs the divider a second time for the sample period and adds one queue read.
//   One beat is in flight at a time; in_ready_o is low until the result is
//   taken. A stalled receiver holds the result and the block waits.
//   Reset empties the queue, stops play, selects the silent wave and loads the
//   default period for a 48 MHz clock. Queue storage is not cleared.
module note_queue_wavetable_synth_top #(
  parameter int unsigned QUEUE_DEPTH = nqws_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [5:0]  note_index_i,
  input  logic [2:0]  wave_select_i,
  input  logic [15:0] note_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] dac_sample_o,
  output logic        playing_o,
  output logic [3:0]  queue_count_o,
  output logic        enqueue_dropped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [27:0] cfg_data_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = (PTR_W + 1 > 4) ? PTR_W + 1 : 4;

  nqws_pkg::state_e state_q, state_d;

  logic [27:0]      clk_hz_q;
  logic [2:0]       vol_q;
  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic             play_q, play_d;
  logic [15:0]      timer_q, timer_d;
  logic [2:0]       active_q, active_d;
  logic [2:0]       shown_q, shown_d;
  logic [7:0]       divisor_q, divisor_d;
  logic [11:0]      last_freq_q, last_freq_d;
  logic [23:0]      reload_q, reload_d;
  logic [23:0]      pcount_q, pcount_d;
  logic [4:0]       sidx_q, sidx_d;
  logic             dropped_q, dropped_d;
  logic [11:0]      dac_q, dac_d;

  logic             in_acc;
  logic [PTR_W-1:0] wp_inc, rp_inc;
  logic             full;
  logic [CNT_W-1:0] count;
  logic [5:0]       note_clamped;
  logic             ram_we;
  nqws_pkg::note_t  ram_wdata, ram_rdata;
  nqws_pkg::div_req_t div_req;
  logic             div_busy, div_done;
  logic [nqws_pkg::DVD_W-1:0] div_quo;
  logic [7:0]       latch_div;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == nqws_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Circular pointers wrap explicitly so any depth works.
  assign wp_inc = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_inc = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign full   = (wp_inc == rp_q);
  assign count  = (wp_q >= rp_q) ? CNT_W'(wp_q - rp_q)
                                 : CNT_W'(CNT_W'(wp_q) + CNT_W'(QUEUE_DEPTH) - CNT_W'(rp_q));

  assign note_clamped = (note_index_i > nqws_pkg::NOTE_MAX) ? nqws_pkg::NOTE_MAX
                                                             : note_index_i;
  assign latch_div    = (vol_q == 3'd0) ? nqws_pkg::DIV_SILENT : 8'(4'd8 - {1'b0, vol_q});

  assign ram_wdata.freq = nqws_pkg::NOTE_HZ[note_clamped];
  assign ram_wdata.wave = wave_select_i;
  assign ram_wdata.len  = note_length_i;

  nqws_ram #(
    .WIDTH ($bits(nqws_pkg::note_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  nqws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer: apply the beat, optionally fetch and dispatch, run the divider
  // for the period on a frequency change and for the sample, then present the result.
  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    play_d      = play_q;
    timer_d     = timer_q;
    active_d    = active_q;
    shown_d     = shown_q;
    divisor_d   = divisor_q;
    last_freq_d = last_freq_q;
    reload_d    = reload_q;
    pcount_d    = pcount_q;
    sidx_d      = sidx_q;
    dropped_d   = dropped_q;
    dac_d       = dac_q;
    ram_we      = 1'b0;
    div_req     = '0;
    out_valid_o = 1'b0;

    case (state_q)
      nqws_pkg::ST_IDLE: begin
        if (in_acc) begin
          dropped_d = 1'b0;
          state_d   = nqws_pkg::ST_SAMP;
          case (nqws_pkg::action_e'(action_i))
            nqws_pkg::ACT_ENQUEUE: begin
              if (full) begin
                dropped_d = 1'b1;
              end else begin
                ram_we = 1'b1;
                wp_d   = wp_inc;
                play_d = 1'b1;
              end
            end
            nqws_pkg::ACT_NOTE: begin
              if (timer_q != 16'd0) begin
                timer_d = timer_q - 1'b1;
              end else if (play_q) begin
                if (rp_q != wp_q) begin
                  state_d = nqws_pkg::ST_FETCH;
                end else begin
                  // Queue drained: stop and fall back to silence.
                  play_d = 1'b0;
                  if (active_q != nqws_pkg::WAVE_SILENT) begin
                    active_d  = nqws_pkg::WAVE_SILENT;
                    shown_d   = nqws_pkg::WAVE_SILENT;
                    divisor_d = latch_div;
                  end
                end
              end
            end
            nqws_pkg::ACT_CLOCK: begin
              if (pcount_q >= reload_q) begin
                pcount_d = '0;
                sidx_d   = sidx_q + 1'b1;
              end else begin
                pcount_d = pcount_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      nqws_pkg::ST_FETCH: begin
        // Wait out the registered queue read.
        state_d = nqws_pkg::ST_POP;
      end
      nqws_pkg::ST_POP: begin
        if (ram_rdata.wave != active_q) begin
          active_d = ram_rdata.wave;
          if (ram_rdata.wave <= nqws_pkg::WAVE_TRI) begin
            shown_d   = ram_rdata.wave;
            divisor_d = latch_div;
          end
        end
        timer_d = ram_rdata.len;
        rp_d    = rp_inc;
        if (ram_rdata.freq != last_freq_q) begin
          last_freq_d      = ram_rdata.freq;
          pcount_d         = '0;
          div_req.start    = 1'b1;
          div_req.dividend = clk_hz_q[27:5];
          div_req.divisor  = ram_rdata.freq;
          state_d          = nqws_pkg::ST_FDIV;
        end else begin
          state_d = nqws_pkg::ST_SAMP;
        end
      end
      nqws_pkg::ST_FDIV: begin
        if (div_done) begin
          reload_d = (div_quo == '0) ? 24'd0 : 24'(div_quo - 1'b1);
          state_d  = nqws_pkg::ST_SAMP;
        end
      end
      nqws_pkg::ST_SAMP: begin
        div_req.start    = 1'b1;
        div_req.dividend = nqws_pkg::DVD_W'(nqws_pkg::wave_value(shown_q, sidx_q));
        div_req.divisor  = nqws_pkg::DSR_W'(divisor_q);
        state_d          = nqws_pkg::ST_SDIV;
      end
      nqws_pkg::ST_SDIV: begin
        if (div_done) begin
          dac_d   = div_quo[11:0];
          state_d = nqws_pkg::ST_RESP;
        end
      end
      nqws_pkg::ST_RESP: begin
        // Hold the result until the receiver takes it.
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = nqws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nqws_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nqws_pkg::ST_IDLE;
      clk_hz_q    <= nqws_pkg::CLOCK_RESET;
      vol_q       <= nqws_pkg::VOLUME_RESET;
      rp_q        <= '0;
      wp_q        <= '0;
      play_q      <= 1'b0;
      timer_q     <= '0;
      active_q    <= nqws_pkg::WAVE_SILENT;
      shown_q     <= nqws_pkg::WAVE_SILENT;
      divisor_q   <= 8'd1;
      last_freq_q <= '0;
      reload_q    <= nqws_pkg::RELOAD_RESET;
      pcount_q    <= '0;
      sidx_q      <= '0;
      dropped_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      play_q      <= play_d;
      timer_q     <= timer_d;
      active_q    <= active_d;
      shown_q     <= shown_d;
      divisor_q   <= divisor_d;
      last_freq_q <= last_freq_d;
      reload_q    <= reload_d;
      pcount_q    <= pcount_d;
      sidx_q      <= sidx_d;
      dropped_q   <= dropped_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (nqws_pkg::cfg_index_e'(cfg_index_i))
          nqws_pkg::CFG_CLOCK:  clk_hz_q <= cfg_data_i;
          nqws_pkg::CFG_VOLUME: vol_q    <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dac_q <= dac_d;
  end

  assign dac_sample_o      = dac_q;
  assign playing_o         = play_q;
  assign queue_count_o     = count[3:0];
  assign enqueue_dropped_o = dropped_q;

`include "note_queue_wavetable_synth_top_assert.svh"

  `NQWS_ASSERT_SAME(a_div_start_free, div_req.start, !div_busy, "divider restarted while busy")
  `NQWS_ASSERT_SAME(a_divisor_nonzero, 1'b1, divisor_q != 8'd0, "volume divisor is zero")
  `NQWS_ASSERT_NEXT(a_full_drop, in_acc && action_i == nqws_pkg::ACT_ENQUEUE && full,
    $stable(wp_q) && enqueue_dropped_o, "enqueue into full queue not dropped")
  `NQWS_ASSERT_SAME(a_count_range, 1'b1, count < CNT_W'(QUEUE_DEPTH), "queue fill out of range")

endmodule

FILE: bench/tb.sv
// Self-checking bench for note_queue_wavetable_synth_top: directed and random beats.
// Depends on nqws_pkg and the top-level RTL; carries its own tone generator predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nqws_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [5:0]  note_index_i = '0;
  logic [2:0]  wave_select_i = '0;
  logic [15:0] note_length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] dac_sample_o;
  logic        playing_o;
  logic [3:0]  queue_count_o;
  logic        enqueue_dropped_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [27:0] cfg_data_i = '0;

  note_queue_wavetable_synth_top u_top (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Expected output beat of the synth.
  typedef struct packed {
    logic [11:0] sample;
    logic        play;
    logic [3:0]  fill;
    logic        dropped;
  } synth_out_t;

  synth_out_t expected_beats[$];
  int unsigned mismatch_count = 0;
  bit          idle_stretch = 1'b0;

  // Shadow state of the tone generator.
  logic [27:0] clk_hz;
  logic [2:0]  vol;
  note_t       note_q[QUEUE_DEPTH];
  logic [3:0]  rd_ptr, wr_ptr;
  logic        play;
  logic [15:0] note_timer;
  logic [2:0]  cur_wave, shown_wave;
  logic [7:0]  divisor;
  logic [11:0] last_hz;
  logic [23:0] reload, period_cnt;
  logic [4:0]  tbl_idx;

  function automatic logic [11:0] table_value(logic [2:0] kind, logic [4:0] idx);
    logic [11:0] v;
    case (kind)
      WAVE_SINE:   v = SINE_TBL[idx];
      WAVE_SQUARE: v = (idx < 5'd16) ? 12'd4095 : 12'd0;
      WAVE_RAMP:   v = SAW_TBL[idx];
      WAVE_TRI:    v = TRI_TBL[idx];
      default:     v = 12'd0;
    endcase
    return v;
  endfunction

  task automatic switch_wave(logic [2:0] w);
    if (w != cur_wave) begin
      cur_wave = w;
      if (w <= WAVE_TRI) begin
        shown_wave = w;
        divisor = (vol == 3'd0) ? DIV_SILENT : 8'(8 - vol);
      end
    end
  endtask

  task automatic advance_synth(logic [1:0] act, logic [5:0] nidx, logic [2:0] w,
                               logic [15:0] len);
    logic [5:0]  n;
    logic        drop;
    int unsigned q;
    synth_out_t  r;
    drop = 1'b0;
    case (act)
      ACT_ENQUEUE: begin
        n = (nidx > NOTE_MAX) ? NOTE_MAX : nidx;
        if (4'(wr_ptr + 1) == rd_ptr) begin
          drop = 1'b1;
        end else begin
          note_q[wr_ptr] = '{freq: NOTE_HZ[n], wave: w, len: len};
          wr_ptr = wr_ptr + 1;
          play = 1'b1;
        end
      end
      ACT_NOTE: begin
        if (note_timer != 0) begin
          note_timer = note_timer - 1;
        end else if (play) begin
          if (rd_ptr != wr_ptr) begin
            switch_wave(note_q[rd_ptr].wave);
            if (note_q[rd_ptr].freq != last_hz) begin
              last_hz = note_q[rd_ptr].freq;
              q = clk_hz / (32 * int'(last_hz));
              reload = (q == 0) ? 24'd0 : 24'(q - 1);
              period_cnt = '0;
            end
            note_timer = note_q[rd_ptr].len;
            rd_ptr = rd_ptr + 1;
          end else begin
            play = 1'b0;
            switch_wave(WAVE_SILENT);
          end
        end
      end
      ACT_CLOCK: begin
        if (period_cnt >= reload) begin
          period_cnt = '0;
          tbl_idx = tbl_idx + 1;
        end else begin
          period_cnt = period_cnt + 1;
        end
      end
      default: ;
    endcase
    r.sample = table_value(shown_wave, tbl_idx) / ((divisor == 0) ? 8'd1 : divisor);
    r.play = play;
    r.fill = wr_ptr - rd_ptr;
    r.dropped = drop;
    expected_beats.push_back(r);
  endtask

  // Send one beat after a random gap; predict it on acceptance.
  // Valid drops only before a nonzero gap, so with a zero gap it stays high into the next beat.
  task automatic send_beat(logic [1:0] act, logic [5:0] nidx, logic [2:0] w,
                           logic [15:0] len);
    int gap;
    gap = idle_stretch ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    note_index_i <= nidx;
    wave_select_i <= w;
    note_length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
    advance_synth(act, nidx, w, len);
  endtask

  // Drop valid, drain all results, then allow for a pending internal step.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [27:0] val);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_CLOCK) clk_hz = val;
    else vol = val[2:0];
  endtask

  // Receiver: stall at random, check every accepted beat against the oldest prediction.
  initial begin
    int stall;
    synth_out_t want;
    @(posedge rst_ni);
    forever begin
      stall = idle_stretch ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        want = expected_beats.pop_front();
        if (dac_sample_o !== want.sample || playing_o !== want.play ||
            queue_count_o !== want.fill || enqueue_dropped_o !== want.dropped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at %0t: exp %0d %0b %0d %0b, got %0d %0b %0d %0b",
                     $realtime, want.sample, want.play, want.fill, want.dropped,
                     dac_sample_o, playing_o, queue_count_o, enqueue_dropped_o);
        end
      end
    end
  end

  // Directed: note extremes, all waves, full queue, idle and timer cases.
  task automatic test_directed();
    send_beat(ACT_NOTE, 6'd0, 3'd0, 16'd0);      // timer zero, play off
    send_beat(ACT_NONE, 6'd63, 3'd7, 16'hFFFF);
    send_beat(ACT_CLOCK, 6'd0, 3'd0, 16'd0);
    for (int i = 0; i < 8; i++)
      send_beat(ACT_ENQUEUE, (i == 0) ? 6'd63 : 6'(i * 8), 3'(i), 16'(i % 2));
    for (int i = 0; i < 10; i++) send_beat(ACT_NOTE, 6'd0, 3'd0, 16'd0);
    send_beat(ACT_CLOCK, 6'd0, 3'd0, 16'd0);
    for (int i = 0; i < 16; i++) send_beat(ACT_ENQUEUE, 6'd59, 3'd1, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_beat(ACT_NOTE, 6'd0, 3'd0, 16'd0);
  endtask

  // Random: mostly short tunes with many clock ticks, some noise.
  task automatic test_random(int beats);
    int r;
    for (int i = 0; i < beats; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20)
        send_beat(ACT_ENQUEUE, 6'($urandom), 3'($urandom),
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3)));
      else if (r < 45) send_beat(ACT_NOTE, 6'($urandom), 3'($urandom), 16'($urandom));
      else if (r < 95) send_beat(ACT_CLOCK, 6'($urandom), 3'($urandom), 16'($urandom));
      else send_beat(ACT_NONE, 6'($urandom), 3'($urandom), 16'($urandom));
    end
  endtask

  // Sweep the core clock and the volume, with random beats after each setting.
  task automatic test_config_sweep();
    logic [27:0] clocks[4] = '{28'd1000000, 28'd200000000, 28'd268435455, 28'd48000000};
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_CLOCK, clocks[k]);
      write_reg(CFG_VOLUME, 28'(k == 0 ? 0 : (k == 1 ? 7 : $urandom_range(0, 7))));
      test_random(200);
      idle_stretch = (k == 1);
    end
    idle_stretch = 1'b0;
  endtask

  initial begin
    clk_hz = CLOCK_RESET;
    vol = VOLUME_RESET;
    rd_ptr = '0; wr_ptr = '0; play = 1'b0; note_timer = '0;
    cur_wave = WAVE_SILENT; shown_wave = WAVE_SILENT; divisor = 8'd1;
    last_hz = '0; reload = RELOAD_RESET; period_cnt = '0; tbl_idx = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200);
    test_config_sweep();
    wait_drain();
    if (mismatch_count == 0 && expected_beats.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
